[hw/rtl/ile_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed list engine package
// Shared constants, command and status codes, and the per-cell control beat.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W     = 32;
    localparam int IDX_W     = 5;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;

    localparam logic [CMD_W-1:0] CMD_INS  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctrl;

endpackage

[hw/rtl/indexed_list_engine.sv]
// A result strobes on o_valid after the command beat is accepted, with r_pend
// registered in between. busy follows r_pend and covers the cycle in which the
// cell row settles and the read and back values are gathered from the cells.
// The receiver cannot stall; a new command is not accepted while busy is high.
// Reset empties the list and clears busy and the strobe; cell contents are
// left as they are and are never read before being written.
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed values held in a row of shifting cells.
// ----------------------------------------------------------------------------
module indexed_list_engine #(
    parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ile_pkg::CMD_W-1:0]         i_command,
    input  logic [ile_pkg::IDX_W-1:0]         i_index,
    input  logic signed [ile_pkg::VAL_W-1:0]  i_value,
    output logic                              o_valid,
    output logic signed [ile_pkg::VAL_W-1:0]  o_read_value,
    output logic signed [ile_pkg::VAL_W-1:0]  o_front_value,
    output logic signed [ile_pkg::VAL_W-1:0]  o_back_value,
    output logic [ile_pkg::IDX_W-1:0]         o_count,
    output logic [ile_pkg::STAT_W-1:0]        o_status
);
    import ile_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (LW > IDX_W) ? LW : IDX_W;

    logic                  w_accept;
    logic [CW-1:0]         w_n;
    logic [CW-1:0]         w_idx;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_past;
    t_cell_ctrl            w_ctrl;
    logic [PW-1:0]         w_pos;
    logic [STAT_W-1:0]     w_status;
    logic [LW-1:0]         n_count;
    logic [PW-1:0]         w_back_pos;

    logic                  r_pend;
    logic [LW-1:0]         r_count;
    logic [STAT_W-1:0]     r_status;
    logic                  r_rd_ok;
    logic [PW-1:0]         r_rd_pos;

    logic signed [VAL_W-1:0] w_value [DEPTH];
    logic signed [VAL_W-1:0] w_rd    [DEPTH];
    logic signed [VAL_W-1:0] w_bk    [DEPTH];
    logic signed [VAL_W-1:0] w_rd_or;
    logic signed [VAL_W-1:0] w_bk_or;

    assign w_accept = start && !busy;
    assign w_n      = CW'(r_count);
    assign w_idx    = CW'(i_index);
    assign w_full   = (r_count == LW'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_past   = (w_idx >= w_n);

    always_comb begin
        w_ctrl.ins = 1'b0;
        w_ctrl.del = 1'b0;
        w_pos      = PW'(w_idx);
        w_status   = ST_OK;
        n_count    = r_count;
        unique case (i_command)
            CMD_INS: begin
                w_pos = w_past ? PW'(w_n) : PW'(w_idx);
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ctrl.ins = w_accept;
                    n_count    = r_count + LW'(1);
                end
            end
            CMD_DEL: begin
                w_pos = w_past ? PW'(w_n - CW'(1)) : PW'(w_idx);
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_ctrl.del = w_accept;
                    n_count    = r_count - LW'(1);
                end
            end
            CMD_READ: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_past) begin
                    w_status = ST_RANGE;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            r_pend  <= w_accept;
            o_valid <= r_pend;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_rd_ok  <= (i_command == CMD_READ) && !w_empty && !w_past;
            r_rd_pos <= PW'(w_idx);
        end
        if (r_pend) begin
            o_read_value  <= r_rd_ok ? w_rd_or : '0;
            o_front_value <= (r_count != '0) ? w_value[0] : '0;
            o_back_value  <= (r_count != '0) ? w_bk_or : '0;
            o_count       <= IDX_W'(CW'(r_count));
            o_status      <= r_status;
        end
    end

    assign busy       = r_pend;
    assign w_back_pos = PW'(r_count - LW'(1));

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_prev;
        logic signed [VAL_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = w_value[g];
        end else begin : g_mid
            assign w_prev = w_value[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_value[g];
        end else begin : g_body
            assign w_next = w_value[g+1];
        end
        ile_cell #(
            .DEPTH (DEPTH),
            .POS   (g),
            .PW    (PW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_pos        (w_pos),
            .i_val        (i_value),
            .i_prev       (w_prev),
            .i_next       (w_next),
            .i_rd_pos     (r_rd_pos),
            .i_back_pos   (w_back_pos),
            .o_value      (w_value[g]),
            .o_rd_value   (w_rd[g]),
            .o_back_value (w_bk[g])
        );
    end

    always_comb begin
        w_rd_or = '0;
        w_bk_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rd_or = w_rd_or | w_rd[i];
            w_bk_or = w_bk_or | w_bk[i];
        end
    end

    a_pend_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> o_valid && !r_pend)
        else $error("Pending command did not produce exactly one strobe.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LW'(DEPTH))
        else $error("Element count exceeds the cell row depth.");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> o_read_value == '0)
        else $error("Read value is nonzero on a failed command.");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_command == CMD_INS) && w_full |=> r_count == $past(r_count))
        else $error("Insert into a full list changed the count.");

endmodule

[hw/rtl/ile_cell.sv]
// ----------------------------------------------------------------------------
// Indexed list engine cell
// Holds one list element and shifts it toward or away from its neighbors.
// ----------------------------------------------------------------------------
module ile_cell #(
    parameter int DEPTH = ile_pkg::DEPTH_DEF,
    parameter int POS   = 0,
    parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                             i_clk,
    input  ile_pkg::t_cell_ctrl              i_ctrl,
    input  logic [PW-1:0]                    i_pos,
    input  logic signed [ile_pkg::VAL_W-1:0] i_val,
    input  logic signed [ile_pkg::VAL_W-1:0] i_prev,
    input  logic signed [ile_pkg::VAL_W-1:0] i_next,
    input  logic [PW-1:0]                    i_rd_pos,
    input  logic [PW-1:0]                    i_back_pos,
    output logic signed [ile_pkg::VAL_W-1:0] o_value,
    output logic signed [ile_pkg::VAL_W-1:0] o_rd_value,
    output logic signed [ile_pkg::VAL_W-1:0] o_back_value
);
    import ile_pkg::*;

    localparam logic [PW-1:0] POS_L = PW'(POS);

    logic signed [VAL_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins) begin
            if (POS_L == i_pos) begin
                r_value <= i_val;
            end else if (POS_L > i_pos) begin
                r_value <= i_prev;
            end
        end else if (i_ctrl.del && (POS_L >= i_pos)) begin
            r_value <= i_next;
        end
    end

    assign o_value      = r_value;
    assign o_rd_value   = (POS_L == i_rd_pos)   ? r_value : '0;
    assign o_back_value = (POS_L == i_back_pos) ? r_value : '0;

endmodule

[test/indexed_list_engine_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed list engine checker
// Watches the command and result channels of the list engine. It keeps a
// shadow copy of the list, predicts one result beat per accepted command,
// and compares every strobed result, field by field, with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module indexed_list_engine_checker #(
    parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic [ile_pkg::CMD_W-1:0]         i_command,
    input  logic [ile_pkg::IDX_W-1:0]         i_index,
    input  logic signed [ile_pkg::VAL_W-1:0]  i_value,
    input  logic                              o_valid,
    input  logic signed [ile_pkg::VAL_W-1:0]  o_read_value,
    input  logic signed [ile_pkg::VAL_W-1:0]  o_front_value,
    input  logic signed [ile_pkg::VAL_W-1:0]  o_back_value,
    input  logic [ile_pkg::IDX_W-1:0]         o_count,
    input  logic [ile_pkg::STAT_W-1:0]        o_status,
    output int                                errors,
    output int                                pending
);
    import ile_pkg::*;

    typedef struct {
        logic signed [VAL_W-1:0] read_value;
        logic signed [VAL_W-1:0] front_value;
        logic signed [VAL_W-1:0] back_value;
        logic [IDX_W-1:0]        count;
        logic [STAT_W-1:0]       status;
    } t_list_result;

    logic signed [VAL_W-1:0] shadow_cells [DEPTH+1];
    int                      shadow_len;
    t_list_result            expected_results [$];
    t_list_result            oldest;

    function automatic t_list_result apply_list_command(
        input logic [CMD_W-1:0]      cmd,
        input logic [IDX_W-1:0]      idx,
        input logic signed [VAL_W-1:0] val
    );
        t_list_result r;
        int           pos;
        r.read_value  = '0;
        r.front_value = '0;
        r.back_value  = '0;
        r.status      = ST_OK;
        case (cmd)
            CMD_INS: begin
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = (idx >= shadow_len) ? shadow_len : idx;
                    for (int i = shadow_len; i > pos; i--) begin
                        shadow_cells[i] = shadow_cells[i-1];
                    end
                    shadow_cells[pos] = val;
                    shadow_len++;
                end
            end
            CMD_DEL: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = (idx >= shadow_len) ? shadow_len - 1 : idx;
                    for (int i = pos; i + 1 < shadow_len; i++) begin
                        shadow_cells[i] = shadow_cells[i+1];
                    end
                    shadow_len--;
                end
            end
            CMD_READ: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (idx >= shadow_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.read_value = shadow_cells[idx];
                end
            end
            default: begin
            end
        endcase
        if (shadow_len > 0) begin
            r.front_value = shadow_cells[0];
            r.back_value  = shadow_cells[shadow_len-1];
        end
        r.count = IDX_W'(shadow_len);
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] exp_v,
                               input logic signed [63:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_len = 0;
            expected_results.delete();
        end else begin
            if (o_valid) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with none expected, expected none, actual count %0d",
                             $time, o_count);
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("read_value", oldest.read_value, o_read_value);
                    check_field("front_value", oldest.front_value, o_front_value);
                    check_field("back_value", oldest.back_value, o_back_value);
                    check_field("count", oldest.count, o_count);
                    check_field("status", oldest.status, o_status);
                end
            end
            if (start && !busy) begin
                expected_results.push_back(apply_list_command(i_command, i_index, i_value));
            end
        end
        pending = expected_results.size();
    end

endmodule

[test/indexed_list_engine_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed list engine testbench
// Drives directed corner commands and then phased random traffic that fills
// and drains the list, with random gaps between command beats. A separate
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module indexed_list_engine_tb;
    import ile_pkg::*;

    localparam int                DEPTH          = DEPTH_DEF;
    localparam int                RANDOM_BEATS   = 1050;
    localparam int                WATCHDOG_LIMIT = 400;
    localparam logic [CMD_W-1:0]  CMD_UNUSED     = 2'd3;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         i_command;
    logic [IDX_W-1:0]         i_index;
    logic signed [VAL_W-1:0]  i_value;
    logic                     o_valid;
    logic signed [VAL_W-1:0]  o_read_value;
    logic signed [VAL_W-1:0]  o_front_value;
    logic signed [VAL_W-1:0]  o_back_value;
    logic [IDX_W-1:0]         o_count;
    logic [STAT_W-1:0]        o_status;
    int                       errors;
    int                       pending;
    int                       stall_cycles;
    bit                       gaps_on;

    indexed_list_engine #(.DEPTH(DEPTH)) dut (.*);

    indexed_list_engine_checker #(.DEPTH(DEPTH)) checker_i (.*);

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue_command(
        input logic [CMD_W-1:0]        cmd,
        input logic [IDX_W-1:0]        idx,
        input logic signed [VAL_W-1:0] val
    );
        int gap;
        gap = gaps_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command <= cmd;
        i_index   <= idx;
        i_value   <= val;
        start     <= 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    initial begin
        int                roll;
        int                mode;
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_command    = CMD_INS;
        i_index      = '0;
        i_value      = '0;
        gaps_on      = 1'b1;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        issue_command(CMD_READ, 5'd0, 32'sd0);
        issue_command(CMD_DEL, 5'd0, 32'sd0);
        issue_command(CMD_UNUSED, 5'd0, 32'sd0);
        issue_command(CMD_INS, 5'd5, 32'sh7FFF_FFFF);
        issue_command(CMD_INS, 5'd0, 32'sh8000_0000);
        issue_command(CMD_INS, 5'd31, -32'sd1);
        issue_command(CMD_INS, 5'd1, 32'sd0);
        issue_command(CMD_READ, 5'd1, 32'sd0);
        issue_command(CMD_READ, 5'd4, 32'sd0);
        issue_command(CMD_READ, 5'd31, 32'sd0);
        issue_command(CMD_DEL, 5'd31, 32'sd0);
        for (int n = 3; n < DEPTH; n++) begin
            issue_command(CMD_INS, (n % 2) ? 5'd16 : IDX_W'($urandom_range(0, n)),
                          pick_value());
        end
        issue_command(CMD_INS, 5'd0, 32'sd1);
        issue_command(CMD_READ, 5'd15, 32'sd0);
        issue_command(CMD_DEL, 5'd16, 32'sd0);
        issue_command(CMD_DEL, 5'd0, 32'sd0);

        mode = 0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 50 == 0) begin
                mode    = $urandom_range(0, 2);
                gaps_on = ($urandom_range(0, 2) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                cmd = CMD_UNUSED;
            end else if (mode == 0) begin
                cmd = (roll < 70) ? CMD_INS : (roll < 85) ? CMD_DEL : CMD_READ;
            end else if (mode == 1) begin
                cmd = (roll < 20) ? CMD_INS : (roll < 75) ? CMD_DEL : CMD_READ;
            end else begin
                cmd = (roll < 35) ? CMD_INS : (roll < 65) ? CMD_DEL : CMD_READ;
            end
            if ($urandom_range(0, 4) == 0) begin
                idx = IDX_W'($urandom_range(0, 31));
            end else begin
                idx = IDX_W'($urandom_range(0, 17));
            end
            issue_command(cmd, idx, pick_value());
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
